// ===== sv/scc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared constants and types for the strongly connected component sizer.
// ----------------------------------------------------------------------------
package scc_pkg;
    localparam int MaxNodes = 256;
    localparam int MaxEdges = 1024;
    localparam int NodeW    = $clog2(MaxNodes);
    localparam int EdgeW    = $clog2(MaxEdges);
    localparam int CntW     = NodeW + 1;
    localparam int EcntW    = EdgeW + 1;

    localparam logic OpLoad    = 1'b0;
    localparam logic OpCompute = 1'b1;

    typedef struct packed {
        logic             op;
        logic [7:0]       edge_from;
        logic [7:0]       edge_to;
    } t_in_item;

    typedef struct packed {
        logic [8:0] source_nodes;
        logic [8:0] sink_nodes;
        logic [8:0] other_nodes;
        logic [8:0] component_total;
        logic       edges_dropped;
    } t_out_item;
endpackage

// ===== sv/scc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_if
// Valid/ready channels: input item, result item and register write.
// ----------------------------------------------------------------------------
interface scc_in_if import scc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface scc_out_if import scc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface scc_cfg_if ();
    logic       valid;
    logic       ready;
    logic [8:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/scc_source_sink_sizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_source_sink_sizer_top
// Kosaraju SCC search over a stored edge table, memory-based sequencer.
// ----------------------------------------------------------------------------
// Load item: accepted every cycle while idle, no result.
// Compute item: an endpoint check of every stored edge, then per pass a visited
//   clear of the n nodes and a depth-first search that scans the edges, checks
//   the visited bit of the head on each tail match and pushes and pops nodes.
// A cross-edge pass and a class sum per component follow; the result is registered
//   once the output slot is free. Reset: node_count 256, empty table, drop flag clear.
module scc_source_sink_sizer_top import scc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    scc_in_if.sink    in_ch,
    scc_out_if.source out_ch,
    scc_cfg_if.sink   cfg_ch
);
    typedef enum logic [26:0] {
        S_IDLE  = 27'h0000001,
        S_CHK   = 27'h0000002,
        S_CHKD  = 27'h0000004,
        S_CLR   = 27'h0000008,
        S_OUTER = 27'h0000010,
        S_OUTR  = 27'h0000020,
        S_OUTV  = 27'h0000040,
        S_PUSH  = 27'h0000080,
        S_TOP   = 27'h0000100,
        S_TOPD  = 27'h0000200,
        S_EREQ  = 27'h0000400,
        S_EDAT  = 27'h0000800,
        S_VCHK  = 27'h0001000,
        S_VDAT  = 27'h0002000,
        S_POP   = 27'h0004000,
        S_P2SEL = 27'h0008000,
        S_P2RD  = 27'h0010000,
        S_P2W   = 27'h0020000,
        S_P2V   = 27'h0040000,
        S_XREQ  = 27'h0080000,
        S_XDAT  = 27'h0100000,
        S_XLT   = 27'h0200000,
        S_XLH   = 27'h0400000,
        S_XCMP  = 27'h0800000,
        S_SUM   = 27'h1000000,
        S_SUMD  = 27'h2000000,
        S_FIN   = 27'h4000000
    } t_state;

    // memories
    logic [7:0]       m_tail  [MaxEdges];
    logic [7:0]       m_head  [MaxEdges];
    logic             m_vis   [MaxNodes];
    logic [NodeW-1:0] m_fin   [MaxNodes];
    logic [NodeW-1:0] m_lab   [MaxNodes];
    logic [NodeW-1:0] m_snode [MaxNodes];
    logic [EcntW-1:0] m_scur  [MaxNodes];
    logic [CntW-1:0]  m_csize [MaxNodes];
    logic             m_cin   [MaxNodes];
    logic             m_cout  [MaxNodes];

    t_state           r_st;
    logic [8:0]       r_ncfg;
    logic [EcntW-1:0] r_ecnt, r_e;
    logic             r_drop, r_dropped, r_rev;
    logic [CntW-1:0]  r_i, r_fcnt, r_comps, r_depth, r_csz;
    logic [NodeW-1:0] r_v, r_to, r_hd, r_cu;
    logic [8:0]       r_src, r_snk, r_oth;
    logic             r_ovalid;
    t_out_item        r_out;

    // registered read data
    logic [7:0]       r_rt, r_rh;
    logic             r_visrd;
    logic [NodeW-1:0] r_tnode, r_finrd, r_labrd;
    logic [EcntW-1:0] r_tcur;
    logic [CntW-1:0]  r_csrd;
    logic             r_cinrd, r_coutrd;

    logic [CntW-1:0] w_n;
    always_comb begin
        if (r_ncfg == 9'd0) w_n = CntW'(1);
        else if (r_ncfg > 9'(MaxNodes)) w_n = CntW'(MaxNodes);
        else w_n = CntW'(r_ncfg);
    end

    logic             w_acc, w_load_ok, w_ok, w_fin, w_close, w_cross;
    logic [7:0]       w_from, w_to;
    logic [NodeW-1:0] w_top, w_fa;

    assign cfg_ch.ready = (r_st == S_IDLE);
    assign in_ch.ready  = (r_st == S_IDLE);
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;

    assign w_acc     = in_ch.valid && in_ch.ready;
    assign w_load_ok = CntW'(in_ch.data.edge_from) < w_n && CntW'(in_ch.data.edge_to) < w_n
                       && r_ecnt < EcntW'(MaxEdges);
    assign w_ok      = CntW'(r_rt) < w_n && CntW'(r_rh) < w_n;
    assign w_from    = r_rev ? r_rh : r_rt;
    assign w_to      = r_rev ? r_rt : r_rh;
    assign w_top     = r_depth[NodeW-1:0] - NodeW'(1);
    assign w_fa      = r_i[NodeW-1:0] - NodeW'(1);
    assign w_fin     = (r_st == S_FIN) && (!r_ovalid || out_ch.ready);
    assign w_close   = (r_st == S_POP) && r_rev && (r_depth == CntW'(1));
    assign w_cross   = (r_st == S_XCMP) && (r_cu != r_labrd);

    always_ff @(posedge i_clk) begin
        if (w_acc && in_ch.data.op == OpLoad && w_load_ok) begin
            m_tail[r_ecnt[EdgeW-1:0]] <= in_ch.data.edge_from;
            m_head[r_ecnt[EdgeW-1:0]] <= in_ch.data.edge_to;
        end
        r_rt <= m_tail[r_e[EdgeW-1:0]];
        r_rh <= m_head[r_e[EdgeW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_CLR && r_i < w_n) m_vis[r_i[NodeW-1:0]] <= 1'b0;
        else if (r_st == S_PUSH) m_vis[r_to] <= 1'b1;
        r_visrd <= m_vis[r_to];
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_PUSH && r_depth < CntW'(MaxNodes)) m_snode[r_depth[NodeW-1:0]] <= r_to;
        if (r_st == S_PUSH && r_depth < CntW'(MaxNodes)) m_scur[r_depth[NodeW-1:0]] <= '0;
        else if (r_st == S_VDAT && !r_visrd) m_scur[w_top] <= r_e + EcntW'(1);
        r_tnode <= m_snode[w_top];
        r_tcur  <= m_scur[w_top];
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_POP && !r_rev && r_fcnt < CntW'(MaxNodes))
            m_fin[r_fcnt[NodeW-1:0]] <= r_v;
        r_finrd <= m_fin[w_fa];
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_PUSH && r_rev) m_lab[r_to] <= r_comps[NodeW-1:0];
        r_labrd <= m_lab[r_to];
    end

    always_ff @(posedge i_clk) begin
        if (w_close) m_csize[r_comps[NodeW-1:0]] <= r_csz;
        if (w_close) m_cin[r_comps[NodeW-1:0]] <= 1'b0;
        else if (w_cross) m_cin[r_labrd] <= 1'b1;
        if (w_close) m_cout[r_comps[NodeW-1:0]] <= 1'b0;
        else if (w_cross) m_cout[r_cu] <= 1'b1;
        r_csrd   <= m_csize[r_i[NodeW-1:0]];
        r_cinrd  <= m_cin[r_i[NodeW-1:0]];
        r_coutrd <= m_cout[r_i[NodeW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_fin) r_ovalid <= 1'b1;
        else if (out_ch.ready) r_ovalid <= 1'b0;
        if (w_fin) r_out <= '{r_src, r_snk, r_oth, r_comps, r_dropped};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ncfg <= 9'd256; r_ecnt <= '0; r_drop <= 1'b0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) r_ncfg <= cfg_ch.data;
            unique case (r_st)
                S_IDLE: if (w_acc) begin
                    if (in_ch.data.op == OpLoad) begin
                        if (w_load_ok) r_ecnt <= r_ecnt + EcntW'(1);
                        else r_drop <= 1'b1;
                    end else begin
                        r_dropped <= r_drop; r_e <= '0; r_st <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_e >= r_ecnt) begin
                        r_rev <= 1'b0; r_i <= '0; r_st <= S_CLR;
                    end else r_st <= S_CHKD;
                end
                S_CHKD: begin
                    if (!w_ok) r_dropped <= 1'b1;
                    r_e <= r_e + EcntW'(1); r_st <= S_CHK;
                end
                S_CLR: begin
                    if (r_i < w_n) r_i <= r_i + CntW'(1);
                    else if (!r_rev) begin
                        r_i <= '0; r_fcnt <= '0; r_st <= S_OUTER;
                    end else begin
                        r_i <= r_fcnt; r_comps <= '0; r_st <= S_P2SEL;
                    end
                end
                S_OUTER: begin
                    if (r_i >= w_n) begin
                        r_rev <= 1'b1; r_i <= '0; r_st <= S_CLR;
                    end else begin
                        r_to <= r_i[NodeW-1:0]; r_st <= S_OUTR;
                    end
                end
                S_OUTR: r_st <= S_OUTV;
                S_OUTV: begin
                    if (r_visrd) begin
                        r_i <= r_i + CntW'(1); r_st <= S_OUTER;
                    end else begin
                        r_depth <= '0; r_csz <= '0; r_st <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (r_depth < CntW'(MaxNodes)) r_depth <= r_depth + CntW'(1);
                    if (r_rev) r_csz <= r_csz + CntW'(1);
                    r_st <= S_TOP;
                end
                S_TOP: r_st <= S_TOPD;
                S_TOPD: begin
                    r_v <= r_tnode; r_e <= r_tcur; r_st <= S_EREQ;
                end
                S_EREQ: begin
                    if (r_e >= r_ecnt) r_st <= S_POP;
                    else r_st <= S_EDAT;
                end
                S_EDAT: begin
                    if (w_ok && w_from == r_v) begin
                        r_to <= w_to; r_st <= S_VCHK;
                    end else begin
                        r_e <= r_e + EcntW'(1); r_st <= S_EREQ;
                    end
                end
                S_VCHK: r_st <= S_VDAT;
                S_VDAT: begin
                    if (r_visrd) begin
                        r_e <= r_e + EcntW'(1); r_st <= S_EREQ;
                    end else r_st <= S_PUSH;
                end
                S_POP: begin
                    if (!r_rev && r_fcnt < CntW'(MaxNodes)) r_fcnt <= r_fcnt + CntW'(1);
                    r_depth <= r_depth - CntW'(1);
                    if (r_depth == CntW'(1)) begin
                        if (r_rev) begin
                            r_comps <= r_comps + CntW'(1); r_st <= S_P2SEL;
                        end else begin
                            r_i <= r_i + CntW'(1); r_st <= S_OUTER;
                        end
                    end else r_st <= S_TOP;
                end
                S_P2SEL: begin
                    if (r_i == '0) begin
                        r_e <= '0; r_st <= S_XREQ;
                    end else r_st <= S_P2RD;
                end
                S_P2RD: begin
                    r_to <= r_finrd; r_st <= S_P2W;
                end
                S_P2W: r_st <= S_P2V;
                S_P2V: begin
                    r_i <= r_i - CntW'(1);
                    if (!r_visrd && r_comps < CntW'(MaxNodes)) begin
                        r_depth <= '0; r_csz <= '0; r_st <= S_PUSH;
                    end else r_st <= S_P2SEL;
                end
                S_XREQ: begin
                    if (r_e >= r_ecnt) begin
                        r_i <= '0; r_src <= '0; r_snk <= '0; r_oth <= '0; r_st <= S_SUM;
                    end else r_st <= S_XDAT;
                end
                S_XDAT: begin
                    if (w_ok) begin
                        r_to <= r_rt; r_hd <= r_rh; r_st <= S_XLT;
                    end else begin
                        r_e <= r_e + EcntW'(1); r_st <= S_XREQ;
                    end
                end
                S_XLT: begin
                    r_to <= r_hd; r_st <= S_XLH;
                end
                S_XLH: begin
                    r_cu <= r_labrd; r_st <= S_XCMP;
                end
                S_XCMP: begin
                    r_e <= r_e + EcntW'(1); r_st <= S_XREQ;
                end
                S_SUM: begin
                    if (r_i >= r_comps) r_st <= S_FIN;
                    else r_st <= S_SUMD;
                end
                S_SUMD: begin
                    if (!r_cinrd && r_coutrd) r_src <= r_src + r_csrd;
                    else if (r_cinrd && !r_coutrd) r_snk <= r_snk + r_csrd;
                    else r_oth <= r_oth + r_csrd;
                    r_i <= r_i + CntW'(1); r_st <= S_SUM;
                end
                S_FIN: begin
                    if (w_fin) begin
                        r_ecnt <= '0; r_drop <= 1'b0; r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
